// ===== rtl/plid_pkg.sv =====
// Package for the positional list block: operation and status codes, the
// command broadcast to the cell row, and default sizing. No dependencies.
`default_nettype none

package plid_pkg;

   localparam int DEFAULT_DEPTH = 128;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_BADPOS = 2'd3
   } status_type;

   // Command seen by every cell in the same cycle.
   typedef struct packed {
      logic               ins_en;  // successful insert this cycle
      logic               del_en;  // successful delete this cycle
      logic [7:0]         pos0;    // zero-based target position
      logic signed [31:0] value;   // value to load on insert
   } cell_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/plid_if.sv =====
// Valid/ready channel interfaces for the positional list block: request beats
// and response beats. No dependencies.
`default_nettype none

interface plid_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic [7:0]         position;
   logic signed [31:0] value;

   modport source (output valid, output op, output position, output value, input ready);
   modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface plid_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] read_value;
   logic [7:0]         count;

   modport source (output valid, output status, output read_value, output count, input ready);
   modport sink   (input valid, input status, input read_value, input count, output ready);
endinterface

`default_nettype wire

// ===== rtl/plid_cell.sv =====
// One list slot: holds, loads the insert value, takes its lower neighbor
// (insert shift) or its upper neighbor (delete shift). Uses plid_pkg.
`default_nettype none

module plid_cell #(
   parameter int INDEX = 0
) (
   input  wire logic                  clock,
   input  wire plid_pkg::cell_cmd_type cmd,
   input  wire logic signed [31:0]    left_data,
   input  wire logic signed [31:0]    right_data,
   output logic signed [31:0]         data
);
   import plid_pkg::*;

   localparam logic [7:0] IDX = 8'(INDEX);

   logic signed [31:0] data_ff;
   logic signed [31:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (cmd.ins_en) begin
         if (IDX == cmd.pos0) begin
            data_in = cmd.value;
         end else if (IDX > cmd.pos0) begin
            data_in = left_data;
         end
      end else if (cmd.del_en && (IDX >= cmd.pos0)) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

// ===== rtl/plid_rdsel.sv =====
// Two-level read select over the cell row: groups of eight are picked and
// registered, then one group word is picked. Uses plid_pkg.
`default_nettype none

module plid_rdsel #(
   parameter int DEPTH = plid_pkg::DEFAULT_DEPTH
) (
   input  wire logic               clock,
   input  wire logic signed [31:0] entries [DEPTH],
   input  wire logic [7:0]         sel,
   output logic signed [31:0]      data
);
   import plid_pkg::*;

   localparam int NGROUP = (DEPTH + 7) / 8;
   localparam int GSEL_W = (NGROUP > 1) ? $clog2(NGROUP) : 1;
   localparam int NSLOT  = 2 ** GSEL_W;

   logic signed [31:0] grp_row [NSLOT][8];
   logic signed [31:0] grp_in  [NSLOT];
   logic signed [31:0] grp_ff  [NSLOT];

   for (genvar g = 0; g < NSLOT; g++) begin : g_grp
      for (genvar k = 0; k < 8; k++) begin : g_slot
         if (g * 8 + k < DEPTH) begin : g_live
            assign grp_row[g][k] = entries[g * 8 + k];
         end else begin : g_pad
            assign grp_row[g][k] = '0;
         end
      end
      assign grp_in[g] = grp_row[g][sel[2:0]];
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

   assign data = grp_ff[sel[3 +: GSEL_W]];

endmodule

`default_nettype wire

// ===== rtl/positional_list_insert_delete.sv =====
// Positional list: top level. Instantiates the cell row (plid_cell) and the
// read select (plid_rdsel); uses plid_pkg and the channel interfaces in plid_if.
//
// Keeps a packed list of up to DEPTH signed 32-bit entries and a count. Each
// request beat carries an op (clear, insert, delete, read) and a 1-based
// position; each request yields exactly one response beat with status, read
// value and the count after the op. The list is a row of cells: on insert
// every cell above the target takes its lower neighbor and the target
// loads the value; on delete every cell at or above the target takes its
// upper neighbor. All cells move in the same clock, so for clear, insert and
// delete the request is taken and the response is registered at the same
// edge, and a new request is taken every cycle as long as the response side
// keeps draining. A successful read goes from the position register through
// a registered group-of-eight select and then a final group select into the
// response register, and no request is taken while it is in flight. Failed
// ops (full, empty, bad position) are answered at the edge that takes them
// and leave the list and count as they were. Entries above the count are
// never read, so the cells need no reset.
`default_nettype none

module positional_list_insert_delete #(
   parameter int DEPTH = plid_pkg::DEFAULT_DEPTH
) (
   input  wire logic  clock,
   input  wire logic  reset,
   plid_req_if.sink   req_chan,
   plid_rsp_if.source rsp_chan
);
   import plid_pkg::*;

   localparam logic [7:0] DEPTH_C = 8'(DEPTH);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RD_GROUP,
      S_RD_FINAL
   } state_type;

   state_type          state_ff;
   logic [7:0]         count_ff;
   logic [7:0]         pos0_ff;
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic signed [31:0] rsp_value_ff;
   logic [7:0]         rsp_count_ff;

   op_type             op;
   logic [7:0]         pos;
   logic               accept;
   status_type         status;
   logic [7:0]         count_in;
   cell_cmd_type       cmd;
   logic signed [31:0] cell_q [DEPTH];
   logic signed [31:0] rd_data;
   logic               rsp_load;

   // Take a beat only from idle and only when the response slot is free
   // (or being emptied this cycle).
   assign req_chan.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   assign op  = op_type'(req_chan.op);
   assign pos = req_chan.position;

   // response slot gets a new beat this cycle
   assign rsp_load = (accept && !((op == OP_READ) && (status == ST_OK)))
                     || (state_ff == S_RD_FINAL);

   // Status and new count. Full / empty take priority over position checks.
   always_comb begin
      status   = ST_OK;
      count_in = count_ff;
      unique case (op)
         OP_CLEAR: begin
            count_in = '0;
         end
         OP_INSERT: begin
            if (count_ff >= DEPTH_C) begin
               status = ST_FULL;
            end else if ((pos == 8'd0) || ({1'b0, pos} > ({1'b0, count_ff} + 9'd1))) begin
               status = ST_BADPOS;
            end else begin
               count_in = count_ff + 8'd1;
            end
         end
         OP_DELETE: begin
            if (count_ff == 8'd0) begin
               status = ST_EMPTY;
            end else if ((pos == 8'd0) || (pos > count_ff)) begin
               status = ST_BADPOS;
            end else begin
               count_in = count_ff - 8'd1;
            end
         end
         OP_READ: begin
            if (count_ff == 8'd0) begin
               status = ST_EMPTY;
            end else if ((pos == 8'd0) || (pos > count_ff)) begin
               status = ST_BADPOS;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   // Broadcast to the cell row; only successful edits move data.
   always_comb begin
      cmd.ins_en = accept && (op == OP_INSERT) && (status == ST_OK);
      cmd.del_en = accept && (op == OP_DELETE) && (status == ST_OK);
      cmd.pos0   = pos - 8'd1;
      cmd.value  = req_chan.value;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [31:0] left_d;
      logic signed [31:0] right_d;
      if (i == 0) begin : g_lo
         assign left_d = cell_q[0];
      end else begin : g_lo_n
         assign left_d = cell_q[i - 1];
      end
      // top cell has no upper neighbor: holding its own value is harmless,
      // it lies past the count after a delete
      if (i == DEPTH - 1) begin : g_hi
         assign right_d = cell_q[i];
      end else begin : g_hi_n
         assign right_d = cell_q[i + 1];
      end
      plid_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (cell_q[i])
      );
   end

   plid_rdsel #(
      .DEPTH (DEPTH)
   ) u_rdsel (
      .clock   (clock),
      .entries (cell_q),
      .sel     (pos0_ff),
      .data    (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  count_ff <= count_in;
                  pos0_ff  <= pos - 8'd1;
                  if ((op == OP_READ) && (status == ST_OK)) begin
                     state_ff <= S_RD_GROUP;
                  end else begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= status;
                     rsp_value_ff  <= '0;
                     rsp_count_ff  <= count_in;
                  end
               end
            end
            S_RD_GROUP: begin
               state_ff <= S_RD_FINAL;
            end
            S_RD_FINAL: begin
               // slot is known free: it was free or draining at accept
               state_ff      <= S_IDLE;
               rsp_valid_ff  <= 1'b1;
               rsp_status_ff <= ST_OK;
               rsp_value_ff  <= rd_data;
               rsp_count_ff  <= count_ff;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.read_value = rsp_value_ff;
   assign rsp_chan.count      = rsp_count_ff;

endmodule

`default_nettype wire

// ===== tb/sv/positional_list_insert_delete_tb.sv =====
// Self-checking testbench for positional_list_insert_delete: directed and random beats,
// each response checked against a shadow copy of the list.
// Depends on plid_pkg (rtl/plid_pkg.sv) and the channel interfaces (rtl/plid_if.sv).
`default_nettype none

module positional_list_insert_delete_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import plid_pkg::*;

   localparam int LIST_DEPTH     = DEFAULT_DEPTH;
   localparam int RANDOM_BEATS   = 1600;
   // A successful read is the slowest op; the rest answer at the edge that takes them.
   localparam int TAIL_CYCLES    = 8;
   // Worst quiet stretch: longest sender gap, read latency, longest response stall.
   localparam int WATCHDOG_LIMIT = 4000;

   // What one response beat should carry.
   typedef struct {
      status_type         status;
      logic signed [31:0] read_value;
      logic [7:0]         count;
   } rsp_fields_type;

   // One row of the directed table; pinned rows carry a hand-typed response.
   typedef struct {
      op_type             op;
      logic [7:0]         position;
      logic signed [31:0] value;
      bit                 pinned;
      rsp_fields_type     fields;
   } list_row_type;

   logic clock;
   logic reset = 1'b1;

   plid_req_if req_bus ();
   plid_rsp_if rsp_bus ();

   positional_list_insert_delete #(
      .DEPTH (LIST_DEPTH)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // --------------------------------------------------------------------
   // Clock and reset
   // --------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // --------------------------------------------------------------------
   // Shadow list: the predictor's own copy of entries and count
   // --------------------------------------------------------------------
   logic signed [31:0] shadow_cells [LIST_DEPTH];
   int                 shadow_len = 0;
   // Copy of shadow_len for the stimulus side, updated by NBA so the driver
   // always reads a settled value (it lags by the beat taken at this edge).
   int                 live_len   = 0;

   rsp_fields_type pending_rsp [$];   // responses still owed by the block
   rsp_fields_type typed_rsp   [$];   // hand-typed override per request beat, in order
   bit             typed_flag  [$];

   int mismatches = 0;
   int rsp_beats  = 0;
   int op_seen     [4];
   int status_seen [4];
   int peak_len   = 0;

   // Applies one op to the shadow list and returns the response it owes.
   // Failed ops leave the list untouched and read back zero.
   function automatic rsp_fields_type apply_list_op(op_type op, logic [7:0] position,
                                                    logic signed [31:0] value);
      rsp_fields_type r;
      int             p;
      p            = int'(position);
      r.status     = ST_OK;
      r.read_value = '0;
      case (op)
         OP_CLEAR: begin
            shadow_len = 0;   // cells keep their old contents
         end
         OP_INSERT: begin
            if (shadow_len >= LIST_DEPTH) begin
               r.status = ST_FULL;   // full wins over a bad position
            end else if (p < 1 || p > shadow_len + 1) begin
               r.status = ST_BADPOS;
            end else begin
               for (int i = shadow_len; i > p - 1; i--) shadow_cells[i] = shadow_cells[i-1];
               shadow_cells[p-1] = value;
               shadow_len++;
            end
         end
         OP_DELETE: begin
            if (shadow_len < 1) begin
               r.status = ST_EMPTY;  // empty wins over a bad position
            end else if (p < 1 || p > shadow_len) begin
               r.status = ST_BADPOS;
            end else begin
               // only cells below the count move, nothing past the end is touched
               for (int i = p - 1; i + 1 < shadow_len; i++) shadow_cells[i] = shadow_cells[i+1];
               shadow_len--;
            end
         end
         default: begin
            if (shadow_len < 1) begin
               r.status = ST_EMPTY;
            end else if (p < 1 || p > shadow_len) begin
               r.status = ST_BADPOS;
            end else begin
               r.read_value = shadow_cells[p-1];
            end
         end
      endcase
      r.count = 8'(shadow_len);
      return r;
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatches++;
      $display("mismatch: %s", msg);
   endtask

   // --------------------------------------------------------------------
   // Monitor: both channels sampled at the rising edge (pre-edge values)
   // --------------------------------------------------------------------
   rsp_fields_type want;
   rsp_fields_type got;
   bit             pin;

   always @(posedge clock) begin
      if (!reset) begin
         // response first: a beat leaving at this edge belongs to an older request
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_beats++;
            if (pending_rsp.size() == 0) begin
               flag_mismatch($sformatf("response beat %0d with nothing pending", rsp_beats));
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_bus.status !== want.status)
                  flag_mismatch($sformatf("beat %0d status %0d, want %0d", rsp_beats,
                                          rsp_bus.status, want.status));
               if (rsp_bus.read_value !== want.read_value)
                  flag_mismatch($sformatf("beat %0d read_value %h, want %h", rsp_beats,
                                          rsp_bus.read_value, want.read_value));
               if (rsp_bus.count !== want.count)
                  flag_mismatch($sformatf("beat %0d count %0d, want %0d", rsp_beats,
                                          rsp_bus.count, want.count));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            got = apply_list_op(op_type'(req_bus.op), req_bus.position, req_bus.value);
            pin = 1'b0;
            if (typed_flag.size() != 0) begin
               pin  = typed_flag.pop_front();
               want = typed_rsp.pop_front();
            end
            pending_rsp.push_back(pin ? want : got);
            op_seen[req_bus.op]++;
            status_seen[got.status]++;
            if (shadow_len > peak_len) peak_len = shadow_len;
            live_len <= shadow_len;
         end
      end
   end

   // --------------------------------------------------------------------
   // Watchdog: cycles in a row without a beat on either channel
   // --------------------------------------------------------------------
   int  quiet_cycles = 0;
   wire any_beat = (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready);

   always @(posedge clock) begin
      if (reset || any_beat) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
         $display("[positional_list_insert_delete] ERROR");
         $finish;
      end
   end

   // --------------------------------------------------------------------
   // Idle gaps: mostly none or short, now and then a long one
   // --------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 95) return $urandom_range(10, 4);
      return $urandom_range(40, 15);
   endfunction

   // Response side back-pressure; rsp_calm turns it off for a stretch.
   bit rsp_calm = 1'b0;
   int stall_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else if (rsp_calm || $urandom_range(99) < 70) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= (pick_gap() > 1) ? pick_gap() : 0;
      end
   end

   // --------------------------------------------------------------------
   // Driver
   // --------------------------------------------------------------------
   bit gaps_on = 1'b1;

   // Presents one request beat and returns at the edge where it is taken.
   task automatic send_beat(input op_type op, input logic [7:0] position,
                            input logic signed [31:0] value, input bit pinned,
                            input rsp_fields_type fields);
      int gap;
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      typed_flag.push_back(pinned);
      typed_rsp.push_back(fields);
      req_bus.valid    <= 1'b1;
      req_bus.op       <= op;
      req_bus.position <= position;
      req_bus.value    <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Sender holds off until every owed response has left the block.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending_rsp.size() != 0 || typed_flag.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // Mostly legal positions, with the ends of the range favored; the rest
   // are zero, one past the range, the top code, or anything at all.
   function automatic logic [7:0] pick_pos(op_type op, int len);
      int top;
      int r;
      top = (op == OP_INSERT) ? len + 1 : len;
      r   = $urandom_range(99);
      if (top >= 1 && r < 85) begin
         r = $urandom_range(9);
         if (r == 0) return 8'd1;
         if (r == 1) return 8'(top);
         return 8'($urandom_range(top, 1));
      end
      r = $urandom_range(3);
      case (r)
         0:       return 8'd0;
         1:       return 8'(top + 1);
         2:       return 8'd255;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   list_row_type opening_rows [$];

   task automatic add_row(input op_type op, input int position, input logic [31:0] value,
                          input bit pinned, input status_type st, input logic [31:0] rd,
                          input int cnt);
      list_row_type row;
      row.op                = op;
      row.position          = 8'(position);
      row.value             = value;
      row.pinned            = pinned;
      row.fields.status     = st;
      row.fields.read_value = rd;
      row.fields.count      = 8'(cnt);
      opening_rows.push_back(row);
   endtask

   rsp_fields_type no_fields;

   initial begin
      int         seg_left;
      int         mode;
      int         r;
      int         base;
      int         sent;
      op_type     op;
      logic [7:0] position;

      req_bus.valid    = 1'b0;
      req_bus.op       = OP_CLEAR;
      req_bus.position = '0;
      req_bus.value    = '0;
      no_fields        = '{ST_OK, '0, '0};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // --- directed table ---------------------------------------------
      // Typed rows: empty list after reset, bad positions at both ends,
      // extreme values, clear. Unpinned rows fall back to the shadow list.
      add_row(OP_READ,     1, 32'h0,        1, ST_EMPTY,  32'h0,        0);
      add_row(OP_DELETE,   1, 32'h0,        1, ST_EMPTY,  32'h0,        0);
      add_row(OP_INSERT,   0, 32'h5,        1, ST_BADPOS, 32'h0,        0);
      add_row(OP_INSERT,   2, 32'h5,        1, ST_BADPOS, 32'h0,        0);
      add_row(OP_INSERT,   1, 32'h7FFFFFFF, 1, ST_OK,     32'h0,        1);
      add_row(OP_INSERT,   1, 32'h80000000, 1, ST_OK,     32'h0,        2);
      add_row(OP_INSERT,   3, 32'h0,        1, ST_OK,     32'h0,        3);
      add_row(OP_INSERT, 255, 32'h1,        1, ST_BADPOS, 32'h0,        3);
      add_row(OP_READ,     1, 32'hFFFFFFFF, 1, ST_OK,     32'h80000000, 3);
      add_row(OP_READ,     2, 32'h0,        1, ST_OK,     32'h7FFFFFFF, 3);
      add_row(OP_READ,     3, 32'h0,        1, ST_OK,     32'h0,        3);
      add_row(OP_READ,     0, 32'h0,        1, ST_BADPOS, 32'h0,        3);
      add_row(OP_READ,     4, 32'h0,        1, ST_BADPOS, 32'h0,        3);
      add_row(OP_DELETE,   0, 32'h0,        1, ST_BADPOS, 32'h0,        3);
      add_row(OP_DELETE,   4, 32'h0,        1, ST_BADPOS, 32'h0,        3);
      add_row(OP_DELETE,   2, 32'h0,        0, ST_OK,     32'h0,        0);  // middle
      add_row(OP_READ,     2, 32'h0,        0, ST_OK,     32'h0,        0);
      add_row(OP_INSERT,   3, 32'hFFFFFFFF, 0, ST_OK,     32'h0,        0);  // append
      add_row(OP_DELETE,   3, 32'h0,        0, ST_OK,     32'h0,        0);  // last
      add_row(OP_DELETE,   1, 32'h0,        0, ST_OK,     32'h0,        0);  // first
      add_row(OP_READ,     1, 32'h0,        0, ST_OK,     32'h0,        0);
      add_row(OP_CLEAR,    7, 32'h0,        1, ST_OK,     32'h0,        0);
      add_row(OP_READ,     1, 32'h0,        1, ST_EMPTY,  32'h0,        0);
      add_row(OP_CLEAR,    0, 32'h0,        1, ST_OK,     32'h0,        0);  // already empty
      add_row(OP_INSERT,   1, 32'h12345,    0, ST_OK,     32'h0,        0);  // reuse after clear
      add_row(OP_READ,   255, 32'h0,        1, ST_BADPOS, 32'h0,        1);

      foreach (opening_rows[i])
         send_beat(opening_rows[i].op, opening_rows[i].position, opening_rows[i].value,
                   opening_rows[i].pinned, opening_rows[i].fields);

      // --- fill to full, then the full-list corner cases ----------------
      wait_drained();
      base = live_len;
      for (int i = 0; i < LIST_DEPTH - base; i++)
         send_beat(OP_INSERT, 8'($urandom_range(base + i + 1, 1)), $urandom, 0, no_fields);
      // full is reported ahead of any position check
      send_beat(OP_INSERT,   1, $urandom, 1, '{ST_FULL,   '0, 8'(LIST_DEPTH)});
      send_beat(OP_INSERT,   0, $urandom, 1, '{ST_FULL,   '0, 8'(LIST_DEPTH)});
      send_beat(OP_READ,   8'(LIST_DEPTH),     '0, 0, no_fields);
      send_beat(OP_READ,   8'(LIST_DEPTH + 1), '0, 1, '{ST_BADPOS, '0, 8'(LIST_DEPTH)});
      send_beat(OP_DELETE, 255, '0, 1, '{ST_BADPOS, '0, 8'(LIST_DEPTH)});
      send_beat(OP_DELETE, 8'(LIST_DEPTH), '0, 0, no_fields);
      send_beat(OP_INSERT, 8'(LIST_DEPTH), $urandom, 0, no_fields);
      send_beat(OP_DELETE, 1, '0, 0, no_fields);
      send_beat(OP_INSERT, 1, $urandom, 0, no_fields);
      wait_drained();

      // --- random segments -------------------------------------------------
      // Each segment leans toward growing, shrinking or churning the list,
      // with a small share of uniformly random beats as noise.
      sent = 0;
      while (sent < RANDOM_BEATS) begin
         seg_left = $urandom_range(120, 20);
         mode     = $urandom_range(3);
         if (live_len < 16 && mode == 1) mode = 0;
         gaps_on  = ($urandom_range(3) != 0);
         rsp_calm <= ($urandom_range(3) == 0);
         while (seg_left > 0 && sent < RANDOM_BEATS) begin
            r = $urandom_range(99);
            case (mode)
               0:       op = (r < 60) ? OP_INSERT : (r < 80) ? OP_READ :
                             (r < 96) ? OP_DELETE : OP_CLEAR;
               1:       op = (r < 15) ? OP_INSERT : (r < 35) ? OP_READ :
                             (r < 97) ? OP_DELETE : OP_CLEAR;
               2:       op = (r < 40) ? OP_INSERT : (r < 70) ? OP_READ :
                             (r < 97) ? OP_DELETE : OP_CLEAR;
               default: op = op_type'($urandom_range(3));
            endcase
            if (mode == 3 || $urandom_range(19) == 0) position = 8'($urandom_range(255));
            else position = pick_pos(op, live_len);
            send_beat(op, position, $urandom, 0, no_fields);
            sent++;
            seg_left--;
         end
         // hold the sender now and then until the block has answered everything
         if ($urandom_range(3) == 0) wait_drained();
      end

      // --- end of run -------------------------------------------------------
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_rsp.size() != 0)
         flag_mismatch($sformatf("%0d responses never arrived", pending_rsp.size()));

      $display("covered: %0d clear, %0d insert, %0d delete, %0d read beats; peak length %0d",
               op_seen[OP_CLEAR], op_seen[OP_INSERT], op_seen[OP_DELETE], op_seen[OP_READ],
               peak_len);
      $display("outcomes: %0d ok, %0d full, %0d empty, %0d bad position; %0d mismatches",
               status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
               status_seen[ST_BADPOS], mismatches);
      if (mismatches == 0) begin
         $display("[positional_list_insert_delete] OK");
      end else begin
         $display("[positional_list_insert_delete] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
